// File: rtl/core/cpid_pkg.sv
package cpid_pkg;

  localparam int MaxWidth = 1024;
  localparam int MaxRow   = 4096;

  localparam int ColW    = 10;
  localparam int RowW    = 12;
  localparam int HeightW = 13;
  localparam int CfgW    = 12;

  typedef enum logic [2:0] {
    CmdNewImage    = 3'd0,
    CmdColumnStart = 3'd1,
    CmdDataByte    = 3'd2,
    CmdTableWrite  = 3'd3,
    CmdReport      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RegMaskZero  = 2'd0,
    RegClipEn    = 2'd1,
    RegClipH     = 2'd2,
    RegTransEn   = 2'd3
  } reg_e;

  localparam logic KindPixel  = 1'b0;
  localparam logic KindReport = 1'b1;

endpackage

// File: rtl/core/cpid_if.sv
interface cpid_in_if;
  import cpid_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          command;
  logic [ColW-1:0]     column_index;
  logic [7:0]          data_byte;
  logic [7:0]          table_index;

  modport source (output valid, command, column_index, data_byte, table_index, input ready);
  modport sink   (input valid, command, column_index, data_byte, table_index, output ready);
endinterface

interface cpid_out_if;
  import cpid_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ColW-1:0]     pixel_column;
  logic [RowW-1:0]     pixel_row;
  logic [7:0]          color_index;
  logic                color_write;
  logic                alpha_opaque;
  logic [HeightW-1:0]  image_height;

  modport source (output valid, kind, pixel_column, pixel_row, color_index, color_write,
                  alpha_opaque, image_height, input ready);
  modport sink   (input valid, kind, pixel_column, pixel_row, color_index, color_write,
                  alpha_opaque, image_height, output ready);
endinterface

// File: rtl/core/column_post_image_decoder.sv
// Channel  Dir  Word
// in_i     in   command, column_index, data_byte, table_index
// out_o    out  kind, pixel_column, pixel_row, color_index, color_write,
//               alpha_opaque, image_height
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One input word per cycle. A result shows up on out_o the cycle after its
// input word is taken; the translation table is a synchronous RAM
// whose read data lands alongside the output register.
// Reset clears parse state, config registers and output valid; the table is not cleared.
// A stalled result holds the output register and stops input acceptance.
module column_post_image_decoder
  import cpid_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  cpid_in_if.sink           in_i,
  cpid_out_if.source        out_o
);

  typedef enum logic [2:0] {
    PhIdle, PhTop, PhLen, PhJunk1, PhPix, PhJunk2
  } phase_e;

  logic            mask_zero_q, clip_en_q, trans_en_q;
  logic [RowW-1:0] clip_h_q;

  phase_e              phase_q, phase_d;
  logic                top_neg_q, top_neg_d;
  logic [RowW-1:0]     top_q, top_d;
  logic [7:0]          pl_q, pl_d;
  logic [HeightW-1:0]  row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [HeightW-1:0]  maxb_q, maxb_d;

  logic                s1_valid_q, s1_valid_d;
  logic                s1_kind_q;
  logic [ColW-1:0]     s1_col_q;
  logic [RowW-1:0]     s1_row_q;
  logic [7:0]          s1_idx_q;
  logic [HeightW-1:0]  s1_height_q;

  logic [7:0] tbl_mem [256];
  logic [7:0] tbl_rdata_q;

  logic                accept, emit_pix, emit_rep, rd_en;
  logic [HeightW-1:0]  top_sum, len_sum;
  logic [7:0]          b;
  logic [7:0]          out_idx;

  assign in_i.ready = !s1_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign top_sum    = {1'b0, top_q} + HeightW'(b);
  assign len_sum    = {1'b0, top_q} + HeightW'(b);

  always_comb begin
    phase_d   = phase_q;
    top_neg_d = top_neg_q;
    top_d     = top_q;
    pl_d      = pl_q;
    row_d     = row_q;
    col_d     = col_q;
    maxb_d    = maxb_q;
    emit_pix  = 1'b0;
    emit_rep  = 1'b0;
    rd_en     = 1'b0;
    if (accept) begin
      case (in_i.command)
        CmdNewImage: begin
          maxb_d    = '0;
          phase_d   = PhIdle;
          top_neg_d = 1'b1;
          pl_d      = '0;
        end
        CmdColumnStart: begin
          top_neg_d = 1'b1;
          pl_d      = '0;
          if (32'(in_i.column_index) < MaxWidth) begin
            col_d   = in_i.column_index;
            phase_d = PhTop;
          end else begin
            phase_d = PhIdle;
          end
        end
        CmdDataByte: begin
          case (phase_q)
            PhTop: begin
              if (b == 8'hff) begin
                phase_d = PhIdle;
              end else begin
                if (!top_neg_q && ({4'd0, b} <= top_q)) begin
                  top_d = (32'(top_sum) > MaxRow - 1) ? RowW'(MaxRow - 1)
                                                      : top_sum[RowW-1:0];
                end else begin
                  top_d = RowW'(b);
                end
                top_neg_d = 1'b0;
                phase_d   = PhLen;
              end
            end
            PhLen: begin
              pl_d  = b;
              row_d = {1'b0, top_q};
              if (b != 8'd0 && len_sum > maxb_q) maxb_d = len_sum;
              phase_d = PhJunk1;
            end
            PhJunk1: begin
              phase_d = (pl_q != 8'd0) ? PhPix : PhJunk2;
            end
            PhPix: begin
              emit_pix = (32'(row_q) < MaxRow) &&
                         !(clip_en_q && row_q >= {1'b0, clip_h_q});
              rd_en    = emit_pix && trans_en_q;
              row_d    = row_q + HeightW'(1);
              pl_d     = pl_q - 8'd1;
              if (pl_q == 8'd1) phase_d = PhJunk2;
            end
            PhJunk2: phase_d = PhTop;
            default: ;
          endcase
        end
        CmdReport: emit_rep = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)            s1_valid_d = emit_pix || emit_rep;
    else if (out_o.ready)  s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_zero_q <= 1'b0;
      clip_en_q   <= 1'b0;
      clip_h_q    <= '0;
      trans_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaskZero: mask_zero_q <= cfg_data_i[0];
        RegClipEn:   clip_en_q   <= cfg_data_i[0];
        RegClipH:    clip_h_q    <= cfg_data_i[RowW-1:0];
        RegTransEn:  trans_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      top_neg_q  <= 1'b1;
      top_q      <= '0;
      pl_q       <= '0;
      row_q      <= '0;
      col_q      <= '0;
      maxb_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      top_neg_q  <= top_neg_d;
      top_q      <= top_d;
      pl_q       <= pl_d;
      row_q      <= row_d;
      col_q      <= col_d;
      maxb_q     <= maxb_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (emit_pix || emit_rep)) begin
      s1_kind_q   <= emit_rep ? KindReport : KindPixel;
      s1_col_q    <= emit_rep ? '0 : col_q;
      s1_row_q    <= emit_rep ? '0 : row_q[RowW-1:0];
      s1_idx_q    <= emit_rep ? '0 : b;
      s1_height_q <= emit_rep ? maxb_q : '0;
    end
  end

  // translation table, one write and one read port
  always_ff @(posedge clk_i) begin
    if (accept && in_i.command == CmdTableWrite) tbl_mem[in_i.table_index] <= b;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) tbl_rdata_q <= tbl_mem[b];
  end

  always_comb begin
    out_idx = '0;
    if (s1_kind_q == KindPixel) out_idx = trans_en_q ? tbl_rdata_q : s1_idx_q;
  end

  assign out_o.valid        = s1_valid_q;
  assign out_o.kind         = s1_kind_q;
  assign out_o.pixel_column = s1_col_q;
  assign out_o.pixel_row    = s1_row_q;
  assign out_o.color_index  = out_idx;
  assign out_o.color_write  = (s1_kind_q == KindPixel) && (!mask_zero_q || out_idx != 8'd0);
  assign out_o.alpha_opaque = (s1_kind_q == KindPixel) && (!mask_zero_q || out_idx != 8'd0);
  assign out_o.image_height = s1_height_q;

  a_pix_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPix |-> pl_q != 8'd0) else $error("pixel phase with no pixels left");

  a_top_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLen || phase_q == PhJunk1 || phase_q == PhPix) |-> !top_neg_q)
    else $error("post body without a running top");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready) else $error("input blocked with empty output stage");

  a_max_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(maxb_q) <= MaxRow - 1 + 255) else $error("max bottom out of range");

endmodule

// File: dv/tb_column_post_image_decoder.sv
`timescale 1ns / 1ps

module tb_column_post_image_decoder;
  import cpid_pkg::*;

  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareHi = 3'd7;
  localparam int TallPosts = 17;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic               kind;
    logic [ColW-1:0]    column;
    logic [RowW-1:0]    row;
    logic [7:0]         index;
    logic               color_write;
    logic               opaque;
    logic [HeightW-1:0] height;
  } out_word_t;

  class column_scoreboard;
    typedef enum int {PhIdle, PhTop, PhLen, PhJunkHead, PhPixel, PhJunkTail} phase_e;

    phase_e             phase = PhIdle;
    int                 run_top = -1;
    logic [7:0]         left = '0;
    logic [HeightW-1:0] row = '0;
    logic [HeightW-1:0] max_bottom = '0;
    logic [ColW-1:0]    column = '0;
    logic [7:0]         xlat [256];
    bit                 written [256];
    bit                 mask_zero;
    bit                 clip_en;
    bit                 xlat_en;
    logic [11:0]        clip_h = '0;
    out_word_t          due_words [$];
    int                 errors;

    function void set_reg(reg_e r, logic [CfgW-1:0] v);
      case (r)
        RegMaskZero: mask_zero = v[0];
        RegClipEn:   clip_en = v[0];
        RegClipH:    clip_h = v[11:0];
        RegTransEn:  xlat_en = v[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // true when this byte would be looked up in a table entry never written
    function bit needs_entry(logic [7:0] b);
      return xlat_en && phase == PhPixel && !written[b];
    endfunction

    function void advance_stream(logic [7:0] b);
      out_word_t          w;
      logic [HeightW-1:0] r;
      logic [7:0]         idx;
      bit                 emit;
      case (phase)
        PhTop: begin
          if (b == 8'hff) begin
            phase = PhIdle;
          end else begin
            if (int'(b) <= run_top) begin
              run_top = run_top + int'(b);
              if (run_top > MaxRow - 1) run_top = MaxRow - 1;
            end else begin
              run_top = int'(b);
            end
            phase = PhLen;
          end
        end
        PhLen: begin
          left = b;
          row = HeightW'(run_top);
          if (b != 0 && row + HeightW'(b) > max_bottom) max_bottom = row + HeightW'(b);
          phase = PhJunkHead;
        end
        PhJunkHead: phase = (left != 0) ? PhPixel : PhJunkTail;
        PhPixel: begin
          r = row;
          emit = (r < MaxRow);
          if (clip_en && r >= HeightW'(clip_h)) emit = 0;
          row = row + 1'b1;
          left = left - 1'b1;
          if (left == 0) phase = PhJunkTail;
          if (emit) begin
            idx = xlat_en ? xlat[b] : b;
            w = '0;
            w.kind = KindPixel;
            w.column = column;
            w.row = r[RowW-1:0];
            w.index = idx;
            w.color_write = !mask_zero || idx != 0;
            w.opaque = !mask_zero || idx != 0;
            due_words = {due_words, w};
          end
        end
        PhJunkTail: phase = PhTop;
        default: ;
      endcase
    endfunction

    function void take_input(logic [2:0] cmd, logic [ColW-1:0] c, logic [7:0] b,
                             logic [7:0] ti);
      out_word_t w;
      case (cmd)
        CmdNewImage: begin
          max_bottom = '0;
          phase = PhIdle;
          run_top = -1;
          left = '0;
        end
        CmdColumnStart: begin
          run_top = -1;
          left = '0;
          column = c;
          phase = PhTop;
        end
        CmdDataByte: advance_stream(b);
        CmdTableWrite: begin
          xlat[ti] = b;
          written[ti] = 1;
        end
        CmdReport: begin
          w = '0;
          w.kind = KindReport;
          w.height = max_bottom;
          due_words = {due_words, w};
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_output(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
        return;
      end
      want = due_words.pop_front();
      cmp("kind", 16'(want.kind), 16'(got.kind));
      cmp("pixel_column", 16'(want.column), 16'(got.column));
      cmp("pixel_row", 16'(want.row), 16'(got.row));
      cmp("color_index", 16'(want.index), 16'(got.index));
      cmp("color_write", 16'(want.color_write), 16'(got.color_write));
      cmp("alpha_opaque", 16'(want.opaque), 16'(got.opaque));
      cmp("image_height", 16'(want.height), 16'(got.height));
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  cpid_in_if  in_if ();
  cpid_out_if out_if ();

  column_post_image_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  column_scoreboard sb = new();
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  bit        hold_req = 0;
  int        hold_left = 0;
  int        words_sent = 0;
  out_word_t seen;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.take_input(in_if.command, in_if.column_index, in_if.data_byte, in_if.table_index);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.kind = out_if.kind;
      seen.column = out_if.pixel_column;
      seen.row = out_if.pixel_row;
      seen.index = out_if.color_index;
      seen.color_write = out_if.color_write;
      seen.opaque = out_if.alpha_opaque;
      seen.height = out_if.image_height;
      sb.check_output(seen);
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // called at a falling edge; returns at the rising edge that takes the word
  task automatic put_word(logic [2:0] cmd, logic [ColW-1:0] col, logic [7:0] b,
                          logic [7:0] ti);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.column_index <= col;
    in_if.data_byte <= b;
    in_if.table_index <= ti;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_word(logic [2:0] cmd, logic [ColW-1:0] col, logic [7:0] b,
                           logic [7:0] ti);
    @(negedge clk_i);
    if (cmd == CmdDataByte && sb.needs_entry(b)) begin
      put_word(CmdTableWrite, ColW'($urandom), 8'($urandom), b);
      @(negedge clk_i);
    end
    put_word(cmd, col, b, ti);
  endtask

  task automatic send_data(logic [7:0] b);
    send_word(CmdDataByte, ColW'($urandom), b, 8'($urandom));
  endtask

  task automatic send_post(logic [7:0] top, logic [7:0] len);
    send_data(top);
    send_data(len);
    send_data(8'($urandom));
    repeat (len) send_data(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
    send_data(8'($urandom));
  endtask

  task automatic gen_column(bit tall);
    int pick;
    logic [7:0] len;
    send_word(CmdColumnStart, ColW'($urandom), 8'($urandom), 8'($urandom));
    if (tall) begin
      // stack zero-length posts until the running top saturates
      repeat (TallPosts) send_post(8'hfe, 8'd0);
      send_post(8'($urandom_range(0, 254)),
                ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(1, 12)));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        pick = $urandom_range(99);
        if (pick < 10) len = 0;
        else if (pick < 97) len = 8'($urandom_range(1, 8));
        else len = 8'($urandom_range(9, 255));
        send_post(($urandom_range(2) == 0) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, 254)),
                  len);
      end
    end
    if ($urandom_range(9) != 0) send_data(8'hff);
  endtask

  task automatic random_traffic(int budget);
    int stop;
    int pick;
    stop = words_sent + budget;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 58) gen_column(0);
      else if (pick < 62) gen_column(1);
      else if (pick < 75)
        repeat ($urandom_range(1, 4))
          send_word(3'($urandom_range(0, 7)), ColW'($urandom), 8'($urandom),
                    8'($urandom));
      else if (pick < 85)
        send_word(CmdReport, ColW'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 90)
        send_word(CmdNewImage, ColW'($urandom), 8'($urandom), 8'($urandom));
      else send_word(CmdTableWrite, ColW'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    sb.set_reg(r, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply(bit mz, bit ce, logic [11:0] ch, bit te, int src_pct, int sink_pct);
    settle();
    write_reg(RegMaskZero, CfgW'(mz));
    write_reg(RegClipEn, CfgW'(ce));
    write_reg(RegClipH, ch);
    write_reg(RegTransEn, CfgW'(te));
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic opening_sequence();
    send_word(CmdReport, '0, '0, '0);
    send_data(8'h5a);
    for (int k = CmdSpareLo; k <= CmdSpareHi; k++) send_word(3'(k), '1, '1, '1);
    send_word(CmdTableWrite, '0, 8'h00, 8'hff);
    send_word(CmdTableWrite, '1, 8'hff, 8'h00);
    send_word(CmdColumnStart, 10'h3ff, '0, '0);
    send_data(8'h00);
    send_data(8'h02);
    send_data(8'hff);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'h00);
    // top not above the running top: added; zero length: no pixels
    send_data(8'h00);
    send_data(8'h00);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'hff);
    send_word(CmdReport, '0, '0, '0);
    send_word(CmdNewImage, '0, '0, '0);
    send_word(CmdReport, '0, '0, '0);
    send_word(CmdColumnStart, '0, '0, '0);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.command = '0;
    in_if.column_index = '0;
    in_if.data_byte = '0;
    in_if.table_index = '0;
    out_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    opening_sequence();

    apply(1, 0, 12'd0, 0, 0, 0);
    hold_req = 1;
    send_word(CmdColumnStart, ColW'($urandom), 8'($urandom), 8'($urandom));
    send_post(8'd0, 8'd60);
    send_data(8'hff);
    random_traffic(300);

    apply(0, 1, 12'd0, 0, 60, 0);
    random_traffic(300);
    apply(1, 1, 12'd4095, 1, 0, 60);
    random_traffic(300);
    apply(0, 1, 12'($urandom_range(1, 40)), 1, 34, 34);
    random_traffic(300);
    apply(1, 0, 12'd2048, 0, 60, 0);
    random_traffic(300);
    apply(0, 1, 12'($urandom_range(0, 4095)), 1, 0, 0);
    random_traffic(300);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("column_post_image_decoder verification clean");
    end else begin
      $display("column_post_image_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("column_post_image_decoder verification failed");
    $finish;
  end

endmodule
